FILE: rtl/core/dictionary_word_break_checker_top_macros.svh
// Assertion helpers for the word-break checker.
// Both sample on i_clk and are disabled while i_rst_n is low.
`ifndef DICTIONARY_WORD_BREAK_CHECKER_TOP_MACROS_SVH
`define DICTIONARY_WORD_BREAK_CHECKER_TOP_MACROS_SVH

// Same-cycle implication
`define DWBC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define DWBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/dwbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dwbc_pkg;

    // Command opcodes
    typedef enum logic [1:0] {
        OP_DICT    = 2'd0,
        OP_TEXT    = 2'd1,
        OP_RESTART = 2'd2,
        OP_CLEAR   = 2'd3
    } t_opcode;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_LONG  = 2'd2,
        STAT_EMPTY = 2'd3
    } t_status;

    localparam int CHAR_W = 8;

endpackage

`default_nettype wire

FILE: rtl/core/dwbc_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Command channel: dictionary bytes, text bytes and control opcodes
interface dwbc_cmd_if;
    logic                      valid;
    logic                      ready;
    dwbc_pkg::t_opcode         opcode;
    logic [dwbc_pkg::CHAR_W-1:0] char_code;
    logic                      end_of_word;

    modport source (output valid, output opcode, output char_code, output end_of_word,
                    input ready);
    modport sink   (input valid, input opcode, input char_code, input end_of_word,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/core/dwbc_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Result channel: one transfer per command
interface dwbc_res_if;
    logic              valid;
    logic              ready;
    logic              segmentable;
    dwbc_pkg::t_status status;

    modport source (output valid, output segmentable, output status, input ready);
    modport sink   (input valid, input segmentable, input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/dictionary_word_break_checker_top.sv
// Channel   Dir  Payload                              Transfer
// i_cmd     in   opcode, char_code, end_of_word       valid & ready
// o_res     out  segmentable, status                  valid & ready
//
// Dictionary, restart and clear commands are handled in ST_IDLE; the result is
// registered at the command transfer. A text byte then holds the block in
// ST_SCAN (which ends at once with an empty dictionary): one stored word
// is read per cycle from the word-row memory and checked by the row comparator.
// Reset (synchronous, active low) empties the dictionary and the text.
// A stalled result holds off the next command transfer.
`timescale 1ns / 1ps
`default_nettype none

module dictionary_word_break_checker_top #(
    parameter int WORD_SLOTS   = 16,
    parameter int MAX_WORD_LEN = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    dwbc_cmd_if.sink    i_cmd,
    dwbc_res_if.source  o_res
);

    localparam int CW     = dwbc_pkg::CHAR_W;
    localparam int CNT_W  = $clog2(WORD_SLOTS + 1);
    localparam int SLOT_W = (WORD_SLOTS > 1) ? $clog2(WORD_SLOTS) : 1;
    localparam int POS_W  = $clog2(MAX_WORD_LEN + 1);
    localparam int LANE_W = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;

    typedef logic [MAX_WORD_LEN-1:0][CW-1:0] t_row;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_word_count, n_word_count;
    logic [POS_W-1:0]    r_load_pos, n_load_pos;
    dwbc_pkg::t_status   r_load_err, n_load_err;
    t_row                r_text, n_text;
    logic [MAX_WORD_LEN:0] r_reach;
    logic [MAX_WORD_LEN:0] n_reach_shift;
    logic [CNT_W-1:0]    r_widx;
    logic                r_rd_vld;
    logic                r_hit;
    logic                r_out_vld;
    logic                r_seg;
    dwbc_pkg::t_status   r_status;

    // Word storage: one row per word, one byte lane per character
    t_row                r_word_mem [WORD_SLOTS];
    logic [POS_W-1:0]    r_len_mem  [WORD_SLOTS];
    t_row                r_row;
    logic [POS_W-1:0]    r_len;

    logic                cmd_xfer;
    logic                slot_free;
    logic                wr_byte;
    logic                wr_len;
    dwbc_pkg::t_status   dict_status;
    logic                rd_issue;
    logic                scan_end;
    logic [MAX_WORD_LEN-1:0] lane_ok;
    logic [POS_W-1:0]    reach_idx;
    logic                row_hit;
    logic                text_clr;

    assign slot_free   = !r_out_vld || o_res.ready;
    assign i_cmd.ready = (r_state == ST_IDLE) && slot_free;
    assign cmd_xfer    = i_cmd.valid && i_cmd.ready;
    assign text_clr    = cmd_xfer && (i_cmd.opcode == dwbc_pkg::OP_RESTART ||
                                      i_cmd.opcode == dwbc_pkg::OP_CLEAR);

    assign o_res.valid       = r_out_vld;
    assign o_res.segmentable = r_seg;
    assign o_res.status      = r_status;

    // Dictionary byte: error tracking, store enables, word commit
    always_comb begin
        n_load_err   = r_load_err;
        n_load_pos   = r_load_pos;
        n_word_count = r_word_count;
        wr_byte      = 1'b0;
        wr_len       = 1'b0;
        if (i_cmd.char_code != '0) begin
            if (n_load_err == dwbc_pkg::STAT_OK && r_word_count >= CNT_W'(WORD_SLOTS)) begin
                n_load_err = dwbc_pkg::STAT_FULL;
            end
            if (r_load_pos >= POS_W'(MAX_WORD_LEN)) begin
                if (n_load_err == dwbc_pkg::STAT_OK) begin
                    n_load_err = dwbc_pkg::STAT_LONG;
                end
            end else begin
                wr_byte    = (n_load_err == dwbc_pkg::STAT_OK);
                n_load_pos = r_load_pos + 1'b1;
            end
        end
        dict_status = n_load_err;
        if (i_cmd.end_of_word) begin
            if (dict_status == dwbc_pkg::STAT_OK && n_load_pos == '0) begin
                dict_status = dwbc_pkg::STAT_EMPTY;
            end
            if (dict_status == dwbc_pkg::STAT_OK) begin
                wr_len       = 1'b1;
                n_word_count = r_word_count + 1'b1;
            end
        end
    end

    // Text window with the new byte shifted in, newest first
    always_comb begin
        n_text[0] = i_cmd.char_code;
        for (int k = 1; k < MAX_WORD_LEN; k++) begin
            n_text[k] = r_text[k-1];
        end
    end

    // Reach history with the scan result shifted in
    always_comb begin
        n_reach_shift[0] = r_hit;
        for (int k = 1; k <= MAX_WORD_LEN; k++) begin
            n_reach_shift[k] = r_reach[k-1];
        end
    end

    // Row comparator: stored word against the tail of the text
    always_comb begin
        for (int k = 0; k < MAX_WORD_LEN; k++) begin
            lane_ok[k] = (POS_W'(k) >= r_len) ||
                         (r_row[k] == r_text[LANE_W'(r_len - POS_W'(k) - 1'b1)]);
        end
        reach_idx = r_len - 1'b1;
        row_hit   = r_rd_vld && (&lane_ok) && r_reach[reach_idx];
    end

    assign rd_issue = (r_state == ST_SCAN) && (r_widx < r_word_count);
    assign scan_end = (r_state == ST_SCAN) && !rd_issue && !r_rd_vld && slot_free;

    // Word memory: byte writes while loading, row reads while scanning
    always_ff @(posedge i_clk) begin
        if (cmd_xfer && i_cmd.opcode == dwbc_pkg::OP_DICT) begin
            if (wr_byte) begin
                r_word_mem[r_word_count[SLOT_W-1:0]][r_load_pos[LANE_W-1:0]] <= i_cmd.char_code;
            end
            if (wr_len) begin
                r_len_mem[r_word_count[SLOT_W-1:0]] <= n_load_pos;
            end
        end
        if (rd_issue) begin
            r_row <= r_word_mem[r_widx[SLOT_W-1:0]];
            r_len <= r_len_mem[r_widx[SLOT_W-1:0]];
        end
    end

    // Sequencer, text state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_word_count <= '0;
            r_load_pos   <= '0;
            r_load_err   <= dwbc_pkg::STAT_OK;
            r_text       <= '0;
            r_reach      <= (MAX_WORD_LEN+1)'(1);
            r_widx       <= '0;
            r_rd_vld     <= 1'b0;
            r_hit        <= 1'b0;
            r_out_vld    <= 1'b0;
            r_seg        <= 1'b0;
            r_status     <= dwbc_pkg::STAT_OK;
        end else begin
            if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (cmd_xfer) begin
                        case (i_cmd.opcode)
                            dwbc_pkg::OP_DICT: begin
                                r_out_vld <= 1'b1;
                                r_seg     <= r_reach[0];
                                r_status  <= dict_status;
                                r_word_count <= n_word_count;
                                if (i_cmd.end_of_word) begin
                                    r_load_pos <= '0;
                                    r_load_err <= dwbc_pkg::STAT_OK;
                                end else begin
                                    r_load_pos <= n_load_pos;
                                    r_load_err <= n_load_err;
                                end
                            end
                            dwbc_pkg::OP_TEXT: begin
                                r_text   <= n_text;
                                r_widx   <= '0;
                                r_rd_vld <= 1'b0;
                                r_hit    <= 1'b0;
                                r_state  <= ST_SCAN;
                            end
                            dwbc_pkg::OP_RESTART: begin
                                r_text    <= '0;
                                r_reach   <= (MAX_WORD_LEN+1)'(1);
                                r_out_vld <= 1'b1;
                                r_seg     <= 1'b1;
                                r_status  <= dwbc_pkg::STAT_OK;
                            end
                            default: begin
                                r_word_count <= '0;
                                r_load_pos   <= '0;
                                r_load_err   <= dwbc_pkg::STAT_OK;
                                r_text       <= '0;
                                r_reach      <= (MAX_WORD_LEN+1)'(1);
                                r_out_vld    <= 1'b1;
                                r_seg        <= 1'b1;
                                r_status     <= dwbc_pkg::STAT_OK;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    r_rd_vld <= rd_issue;
                    if (rd_issue) begin
                        r_widx <= r_widx + 1'b1;
                    end
                    if (row_hit) begin
                        r_hit <= 1'b1;
                    end
                    if (scan_end) begin
                        r_reach   <= n_reach_shift;
                        r_out_vld <= 1'b1;
                        r_seg     <= r_hit;
                        r_status  <= dwbc_pkg::STAT_OK;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`include "dictionary_word_break_checker_top_macros.svh"

    `DWBC_ASSERT_NOW(a_count_bound, 1'b1, r_word_count <= CNT_W'(WORD_SLOTS), "count past slots")
    `DWBC_ASSERT_NOW(a_pos_bound, 1'b1, r_load_pos <= POS_W'(MAX_WORD_LEN), "position past max")
    `DWBC_ASSERT_NOW(a_scan_idx, r_state == ST_SCAN, r_widx <= r_word_count, "index past count")
    `DWBC_ASSERT_NEXT(a_restart_reach, text_clr, r_reach[0] && r_out_vld && r_seg, "text not reset")

endmodule

`default_nettype wire

FILE: tb/dictionary_word_break_checker_top_tb.sv
`timescale 1ns / 1ps

module dictionary_word_break_checker_top_tb;

    localparam int WORD_SLOTS   = 16;
    localparam int MAX_WORD_LEN = 16;
    localparam int RANDOM_ITEMS = 1900;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int N_DIRECTED   = 26;

    // One result transfer: reachability flag and load status
    typedef struct packed {
        logic              seg;
        dwbc_pkg::t_status st;
    } t_break_result;

    // One row of the directed stimulus; fixed_exp rows carry a typed answer
    typedef struct {
        dwbc_pkg::t_opcode op;
        logic [7:0]        ch;
        logic              eow;
        int                reps;
        bit                fixed_exp;
        logic              seg;
        dwbc_pkg::t_status st;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dwbc_cmd_if cmd_ch ();
    dwbc_res_if res_ch ();

    dictionary_word_break_checker_top #(
        .WORD_SLOTS   (WORD_SLOTS),
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: stored words, word under load, text history
    logic [7:0]            word_bytes [WORD_SLOTS][MAX_WORD_LEN];
    logic [4:0]            word_len [WORD_SLOTS];
    logic [4:0]            word_cnt;
    logic [4:0]            load_pos;
    dwbc_pkg::t_status     load_err;
    logic [7:0]            recent_text [MAX_WORD_LEN];
    logic [MAX_WORD_LEN:0] reach_bits;   // bit 0 is the newest position

    t_break_result expected_results [$];
    t_stim_row     directed_rows [N_DIRECTED];
    logic [7:0]    alpha [4];

    int err_cnt       = 0;
    int n_sent        = 0;
    int n_text        = 0;
    int n_checked     = 0;
    int n_stored      = 0;
    int n_rejected    = 0;
    int n_reached     = 0;
    int burst_left    = 0;
    int idle_cycles   = 0;

    function automatic void clear_text_history();
        int k;
        for (k = 0; k < MAX_WORD_LEN; k++) recent_text[k] = 8'h00;
        reach_bits = '0;
        reach_bits[0] = 1'b1;
    endfunction

    // Advance the word-break state by one command and return its result
    function automatic t_break_result advance_word_break(dwbc_pkg::t_opcode op,
                                                         logic [7:0] ch, logic eow);
        dwbc_pkg::t_status code;
        logic              hit;
        bit                match;
        int                w;
        int                j;
        int                len;
        t_break_result     res;
        code = dwbc_pkg::STAT_OK;
        case (op)
            dwbc_pkg::OP_DICT: begin
                // null byte adds nothing; errors latch first cause only
                if (ch != 8'h00) begin
                    if (load_err == dwbc_pkg::STAT_OK && word_cnt >= WORD_SLOTS) begin
                        load_err = dwbc_pkg::STAT_FULL;
                    end
                    if (load_pos >= MAX_WORD_LEN) begin
                        if (load_err == dwbc_pkg::STAT_OK) load_err = dwbc_pkg::STAT_LONG;
                    end else begin
                        if (load_err == dwbc_pkg::STAT_OK) word_bytes[word_cnt][load_pos] = ch;
                        load_pos++;
                    end
                end
                code = load_err;
                if (eow) begin
                    if (code == dwbc_pkg::STAT_OK && load_pos == 0) code = dwbc_pkg::STAT_EMPTY;
                    if (code == dwbc_pkg::STAT_OK) begin
                        word_len[word_cnt] = load_pos;
                        word_cnt++;
                    end
                    load_pos = '0;
                    load_err = dwbc_pkg::STAT_OK;
                end
            end
            dwbc_pkg::OP_TEXT: begin
                for (j = MAX_WORD_LEN - 1; j > 0; j--) recent_text[j] = recent_text[j-1];
                recent_text[0] = ch;
                hit = 1'b0;
                // a word ends here if it matches the tail and its start was reachable
                for (w = 0; w < word_cnt && !hit; w++) begin
                    len = word_len[w];
                    if (len > 0 && len <= MAX_WORD_LEN && reach_bits[len-1]) begin
                        match = 1'b1;
                        for (j = 0; j < len; j++)
                            if (recent_text[j] != word_bytes[w][len-1-j]) match = 1'b0;
                        if (match) hit = 1'b1;
                    end
                end
                reach_bits = {reach_bits[MAX_WORD_LEN-1:0], hit};
            end
            dwbc_pkg::OP_RESTART: begin
                clear_text_history();
            end
            default: begin
                word_cnt = '0;
                load_pos = '0;
                load_err = dwbc_pkg::STAT_OK;
                clear_text_history();
            end
        endcase
        res.seg = reach_bits[0];
        res.st  = code;
        return res;
    endfunction

    // Present one command, wait for its transfer, then queue its expected result
    task automatic send_cmd(dwbc_pkg::t_opcode op, logic [7:0] ch, logic eow, bit fixed_exp,
                            logic exp_seg, dwbc_pkg::t_status exp_st);
        int            gap;
        t_break_result pred;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.opcode      <= op;
        cmd_ch.char_code   <= ch;
        cmd_ch.end_of_word <= eow;
        do @(posedge i_clk); while (!cmd_ch.ready);
        burst_left--;
        n_sent++;
        if (op == dwbc_pkg::OP_TEXT) n_text++;
        pred = advance_word_break(op, ch, eow);
        if (op == dwbc_pkg::OP_TEXT && pred.seg) n_reached++;
        if (op == dwbc_pkg::OP_DICT && eow) begin
            if (pred.st == dwbc_pkg::STAT_OK) n_stored++;
            else n_rejected++;
        end
        if (fixed_exp) begin
            pred.seg = exp_seg;
            pred.st  = exp_st;
        end
        expected_results.push_back(pred);
    endtask

    task automatic send_pred(dwbc_pkg::t_opcode op, logic [7:0] ch, logic eow);
        send_cmd(op, ch, eow, 1'b0, 1'b0, dwbc_pkg::STAT_OK);
    endtask

    // Load one word drawn from the current alphabet, with optional stray nulls
    task automatic load_word(int len, bit with_nulls);
        int k;
        bit null_end;
        null_end = ($urandom_range(0, 4) == 0) || (len == 0);
        for (k = 0; k < len; k++) begin
            if (with_nulls && $urandom_range(0, 5) == 0)
                send_pred(dwbc_pkg::OP_DICT, 8'h00, 1'b0);
            send_pred(dwbc_pkg::OP_DICT, alpha[$urandom_range(0, 3)],
                      !null_end && (k == len - 1));
        end
        if (null_end) send_pred(dwbc_pkg::OP_DICT, 8'h00, 1'b1);
    endtask

    // Text built mostly from stored words so that reachability stays alive
    task automatic send_text_run(int len);
        int emitted;
        int w;
        int k;
        emitted = 0;
        while (emitted < len) begin
            if (word_cnt > 0 && $urandom_range(0, 99) < 85) begin
                w = $urandom_range(0, word_cnt - 1);
                for (k = 0; k < word_len[w] && emitted < len; k++) begin
                    send_pred(dwbc_pkg::OP_TEXT, word_bytes[w][k], 1'($urandom_range(0, 1)));
                    emitted++;
                end
            end else begin
                if ($urandom_range(0, 9) == 0)
                    send_pred(dwbc_pkg::OP_TEXT, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                else
                    send_pred(dwbc_pkg::OP_TEXT, alpha[$urandom_range(0, 3)], 1'b0);
                emitted++;
            end
        end
    endtask

    task automatic new_alphabet();
        int k;
        for (k = 0; k < 4; k++) alpha[k] = 8'($urandom_range(0, 255));
    endtask

    task automatic run_random(int target);
        int kind;
        int k;
        int n;
        while (n_sent < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 8) begin
                // noise: any opcode, any byte
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++)
                    send_pred(dwbc_pkg::t_opcode'($urandom_range(0, 3)),
                              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else if (kind < 13) begin
                new_alphabet();
                send_pred(dwbc_pkg::OP_CLEAR, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            end else if (kind < 36) begin
                n = $urandom_range(0, 19);
                if (n < 15) load_word($urandom_range(1, 4), 1'b0);
                else if (n < 17) load_word($urandom_range(1, 4), 1'b1);
                else if (n < 18) load_word(0, 1'($urandom_range(0, 1)));
                else load_word($urandom_range(MAX_WORD_LEN - 1, MAX_WORD_LEN + 3), 1'b0);
            end else if (kind < 39) begin
                // fill the dictionary and push one word past the last slot
                while (word_cnt < WORD_SLOTS) load_word($urandom_range(1, 3), 1'b0);
                load_word($urandom_range(1, 3), 1'b0);
            end else if (kind < 45) begin
                send_pred(dwbc_pkg::OP_RESTART, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            end else begin
                send_text_run($urandom_range(1, 24));
            end
        end
    endtask

    // Result side: stall pattern plus in-order check against the oldest expectation
    initial begin
        int            cyc;
        t_break_result exp_res;
        res_ch.ready <= 1'b0;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (res_ch.valid && res_ch.ready) begin
                    n_checked++;
                    if (expected_results.size() == 0) begin
                        $error("result transfer with no expectation waiting: seg %0d status %0d",
                               res_ch.segmentable, res_ch.status);
                        err_cnt++;
                    end else begin
                        exp_res = expected_results.pop_front();
                        if (res_ch.segmentable !== exp_res.seg) begin
                            $error("segmentable: expected %0d, actual %0d",
                                   exp_res.seg, res_ch.segmentable);
                            err_cnt++;
                        end
                        if (res_ch.status !== exp_res.st) begin
                            $error("status: expected %0d, actual %0d",
                                   exp_res.st, res_ch.status);
                            err_cnt++;
                        end
                    end
                end
                cyc++;
                case ((cyc / 256) % 4)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= (cyc % 4) != 3;
                    2:       res_ch.ready <= 1'($urandom_range(0, 1));
                    default: res_ch.ready <= (cyc % 37) >= 25;
                endcase
            end
        end
    end

    // Watchdog: cycles without any transfer on either channel
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("dictionary_word_break_checker_top regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus: reset, directed table, random traffic, drain
    initial begin
        int r;
        int k;
        i_rst_n            <= 1'b0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.opcode      <= dwbc_pkg::OP_DICT;
        cmd_ch.char_code   <= 8'h00;
        cmd_ch.end_of_word <= 1'b0;
        word_cnt = '0;
        load_pos = '0;
        load_err = dwbc_pkg::STAT_OK;
        clear_text_history();
        new_alphabet();

        directed_rows = '{
            '{dwbc_pkg::OP_CLEAR,   8'hFF, 1'b1, 1,  1'b1, 1'b1, dwbc_pkg::STAT_OK},
            // empty dictionary
            '{dwbc_pkg::OP_TEXT,    "a",   1'b0, 1,  1'b1, 1'b0, dwbc_pkg::STAT_OK},
            '{dwbc_pkg::OP_TEXT,    8'h00, 1'b1, 1,  1'b1, 1'b0, dwbc_pkg::STAT_OK},
            '{dwbc_pkg::OP_RESTART, 8'hFF, 1'b1, 1,  1'b1, 1'b1, dwbc_pkg::STAT_OK},
            // empty word
            '{dwbc_pkg::OP_DICT,    8'h00, 1'b1, 1,  1'b1, 1'b1, dwbc_pkg::STAT_EMPTY},
            '{dwbc_pkg::OP_DICT,    "a",   1'b0, 1,  1'b1, 1'b1, dwbc_pkg::STAT_OK},
            // null inside a word
            '{dwbc_pkg::OP_DICT,    8'h00, 1'b0, 1,  1'b0, 1'b0, dwbc_pkg::STAT_OK},
            '{dwbc_pkg::OP_DICT,    "b",   1'b1, 1,  1'b0, 1'b0, dwbc_pkg::STAT_OK},
            '{dwbc_pkg::OP_DICT,    8'hFF, 1'b1, 1,  1'b0, 1'b0, dwbc_pkg::STAT_OK},
            '{dwbc_pkg::OP_TEXT,    "a",   1'b0, 1,  1'b0, 1'b0, dwbc_pkg::STAT_OK},
            '{dwbc_pkg::OP_TEXT,    "b",   1'b0, 1,  1'b0, 1'b0, dwbc_pkg::STAT_OK},
            // text reach unchanged
            '{dwbc_pkg::OP_DICT,    "e",   1'b1, 1,  1'b0, 1'b0, dwbc_pkg::STAT_OK},
            '{dwbc_pkg::OP_TEXT,    8'hFF, 1'b0, 1,  1'b0, 1'b0, dwbc_pkg::STAT_OK},
            '{dwbc_pkg::OP_TEXT,    8'h00, 1'b0, 1,  1'b0, 1'b0, dwbc_pkg::STAT_OK},
            '{dwbc_pkg::OP_RESTART, 8'h00, 1'b0, 1,  1'b1, 1'b1, dwbc_pkg::STAT_OK},
            // two bytes too many
            '{dwbc_pkg::OP_DICT,    "x",   1'b0, 17, 1'b0, 1'b0, dwbc_pkg::STAT_OK},
            '{dwbc_pkg::OP_DICT,    "x",   1'b1, 1,  1'b1, 1'b1, dwbc_pkg::STAT_LONG},
            // duplicates fill slots
            '{dwbc_pkg::OP_DICT,    "c",   1'b1, 13, 1'b0, 1'b0, dwbc_pkg::STAT_OK},
            '{dwbc_pkg::OP_DICT,    "d",   1'b0, 1,  1'b1, 1'b1, dwbc_pkg::STAT_FULL},
            '{dwbc_pkg::OP_DICT,    "d",   1'b1, 1,  1'b1, 1'b1, dwbc_pkg::STAT_FULL},
            '{dwbc_pkg::OP_TEXT,    "c",   1'b0, 2,  1'b0, 1'b0, dwbc_pkg::STAT_OK},
            '{dwbc_pkg::OP_TEXT,    "a",   1'b0, 1,  1'b0, 1'b0, dwbc_pkg::STAT_OK},
            '{dwbc_pkg::OP_TEXT,    "b",   1'b1, 1,  1'b0, 1'b0, dwbc_pkg::STAT_OK},
            '{dwbc_pkg::OP_CLEAR,   8'h00, 1'b0, 1,  1'b1, 1'b1, dwbc_pkg::STAT_OK},
            // dictionary cleared
            '{dwbc_pkg::OP_TEXT,    "c",   1'b0, 1,  1'b1, 1'b0, dwbc_pkg::STAT_OK},
            '{dwbc_pkg::OP_RESTART, 8'h5A, 1'b0, 1,  1'b1, 1'b1, dwbc_pkg::STAT_OK}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < N_DIRECTED; r++)
            for (k = 0; k < directed_rows[r].reps; k++)
                send_cmd(directed_rows[r].op, directed_rows[r].ch, directed_rows[r].eow,
                         directed_rows[r].fixed_exp, directed_rows[r].seg,
                         directed_rows[r].st);

        run_random(n_sent + RANDOM_ITEMS);
        cmd_ch.valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            err_cnt++;
        end

        $display("Sent %0d commands, %0d of them text bytes (%0d reachable); %0d results checked.",
                 n_sent, n_text, n_reached, n_checked);
        $display("Dictionary loads: %0d words stored, %0d rejected (full, too long or empty).",
                 n_stored, n_rejected);
        if (err_cnt == 0) begin
            $display("dictionary_word_break_checker_top regression: pass");
        end else begin
            $display("dictionary_word_break_checker_top regression: fail");
        end
        $finish;
    end

endmodule
